>>> sv/modular_exponentiation_top_assert.svh
// ----------------------------------------------------------------------------
// Modular exponentiation assertion macros
// Shared concurrent assertion forms used by the exponentiation modules.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_TOP_ASSERT_SVH
`define MODULAR_EXPONENTIATION_TOP_ASSERT_SVH

// Checked only while the block is out of reset.
`define MX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define MX_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> sv/modexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Widths, register indexes, reset values and sequencer states.
// ----------------------------------------------------------------------------
package modexp_pkg;

  localparam int unsigned DataWidth   = 31;
  localparam int unsigned CfgIdxWidth = 2;

  localparam int unsigned ModulusReset = 3233;
  localparam int unsigned PubExpReset  = 17;
  localparam int unsigned PrivExpReset = 2753;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_MODULUS  = 2'd0,
    REG_PUB_EXP  = 2'd1,
    REG_PRIV_EXP = 2'd2
  } reg_idx_e;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_REDUCE  = 6'b000010,
    ST_STEP    = 6'b000100,
    ST_MUL_ACC = 6'b001000,
    ST_SQUARE  = 6'b010000,
    ST_FINISH  = 6'b100000
  } state_e;

endpackage

>>> sv/modular_exponentiation_top.sv
// ----------------------------------------------------------------------------
// Modular exponentiation top level
// Raises each input word to the public or private exponent modulo the modulus.
// ----------------------------------------------------------------------------
// Usage: write the modulus, public exponent and private exponent through the
// configuration port while the block is idle. Each input word carries a value
// and a request type; type 0 uses the public exponent, type 1 the private one.
// One result word is returned per input word, in order.
// The value is first reduced modulo the modulus by one multiply.
// Then, for each exponent bit from the least significant up to the highest set
// bit, there is a decision step, a multiply into the accumulator when the
// bit is set and a squaring when more bits follow. With a zero exponent or a
// modulus below two the sequencer skips the multiplies and goes straight to
// its finish state. The shared bit-serial multiplier does every multiply, so
// one word is in work at a time.
// The next input word is accepted as soon as the sequencer is idle, even while
// the previous result still waits in the output register. When the receiver
// stalls, a finished result waits in the sequencer until the register frees.
// Reset restores the register reset values and empties the block.
// ----------------------------------------------------------------------------
module modular_exponentiation_top
  import modexp_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [DATA_WIDTH-1:0]  cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   req_type_i,
  input  logic [DATA_WIDTH-1:0]  value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [DATA_WIDTH-1:0]  result_o
);

  logic [DATA_WIDTH-1:0] mod_q, pub_q, priv_q;

  state_e                st_q, st_d;
  logic [DATA_WIDTH-1:0] exp_q, exp_d;
  logic [DATA_WIDTH-1:0] acc_q, acc_d;
  logic [DATA_WIDTH-1:0] base_q, base_d;
  logic                  out_valid_q, out_valid_d;
  logic [DATA_WIDTH-1:0] result_q, result_d;

  logic                  mul_start;
  logic [DATA_WIDTH-1:0] mul_a, mul_b, mul_p;
  logic                  mul_done;

  logic [DATA_WIDTH-1:0] exp_sel;
  logic                  mod_le1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q  <= DATA_WIDTH'(ModulusReset);
      pub_q  <= DATA_WIDTH'(PubExpReset);
      priv_q <= DATA_WIDTH'(PrivExpReset);
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_MODULUS:  mod_q  <= cfg_wdata_i;
        REG_PUB_EXP:  pub_q  <= cfg_wdata_i;
        REG_PRIV_EXP: priv_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign exp_sel = req_type_i ? priv_q : pub_q;
  assign mod_le1 = (mod_q[DATA_WIDTH-1:1] == '0);

  always_comb begin
    st_d        = st_q;
    exp_d       = exp_q;
    acc_d       = acc_q;
    base_d      = base_q;
    out_valid_d = out_valid_q && out_stall_i;
    result_d    = result_q;
    mul_start   = 1'b0;
    mul_a       = acc_q;
    mul_b       = base_q;
    case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          exp_d = exp_sel;
          if ((mod_q == '0) || (mod_le1 && (exp_sel != '0))) begin
            acc_d = '0;
            st_d  = ST_FINISH;
          end else if (exp_sel == '0) begin
            acc_d = DATA_WIDTH'(1);
            st_d  = ST_FINISH;
          end else begin
            acc_d     = DATA_WIDTH'(1);
            mul_start = 1'b1;
            mul_a     = value_i;
            mul_b     = DATA_WIDTH'(1);
            st_d      = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (mul_done) begin
          base_d = mul_p;
          st_d   = ST_STEP;
        end
      end
      ST_STEP: begin
        mul_start = 1'b1;
        if (exp_q[0]) begin
          st_d = ST_MUL_ACC;
        end else begin
          mul_a = base_q;
          exp_d = exp_q >> 1;
          st_d  = ST_SQUARE;
        end
      end
      ST_MUL_ACC: begin
        if (mul_done) begin
          acc_d = mul_p;
          exp_d = exp_q >> 1;
          if (exp_q[DATA_WIDTH-1:1] != '0) begin
            mul_start = 1'b1;
            mul_a     = base_q;
            st_d      = ST_SQUARE;
          end else begin
            st_d = ST_FINISH;
          end
        end
      end
      ST_SQUARE: begin
        if (mul_done) begin
          base_d = mul_p;
          st_d   = ST_STEP;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          result_d    = acc_q;
          st_d        = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q    <= exp_d;
    acc_q    <= acc_d;
    base_q   <= base_d;
    result_q <= result_d;
  end

  modexp_mul #(
    .W(DATA_WIDTH)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .m_i    (mod_q),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  assign in_stall_o  = (st_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

`include "modular_exponentiation_top_assert.svh"

  `MX_ASSERT(a_step_exp_nonzero, (st_q == ST_STEP) |-> (exp_q != '0), "exponent empty in step")
  `MX_ASSERT(a_done_in_mul_state,
    mul_done |-> (st_q == ST_REDUCE || st_q == ST_MUL_ACC || st_q == ST_SQUARE),
    "multiplier finished outside a multiply state")
  `MX_ASSERT(a_finish_reduced, (st_q == ST_FINISH && !mod_le1) |-> (acc_q < mod_q),
    "result not reduced below the modulus")

endmodule

>>> sv/modexp_mul.sv
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Interleaved multiply and reduce, one bit of the first operand per cycle,
// most significant bit first. The second operand must be below the modulus.
// ----------------------------------------------------------------------------
module modexp_mul
  import modexp_pkg::*;
#(
  parameter int unsigned W = DataWidth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] m_i,
  output logic         done_o,
  output logic [W-1:0] p_o
);

  localparam int unsigned CntW = $clog2(W);
  localparam int unsigned TW   = W + 2;

  logic [W-1:0]    a_q, a_d;
  logic [W-1:0]    b_q, b_d;
  logic [W-1:0]    r_q, r_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;

  logic [TW-1:0] sum;
  logic [TW:0]   diff1;
  logic [TW:0]   diff2;
  logic [W-1:0]  addend;

  always_comb begin
    addend = a_q[W-1] ? b_q : '0;
    sum    = {1'b0, r_q, 1'b0} + {2'b00, addend};
    diff1  = {1'b0, sum} - {3'b000, m_i};
    diff2  = {1'b0, sum} - {2'b00, m_i, 1'b0};
    if (!diff2[TW]) begin
      r_d = diff2[W-1:0];
    end else if (!diff1[TW]) begin
      r_d = diff1[W-1:0];
    end else begin
      r_d = sum[W-1:0];
    end
  end

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = busy_q && (cnt_q == '0);
    if (start_i) begin
      a_d    = a_i;
      b_d    = b_i;
      cnt_d  = CntW'(W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      a_d   = {a_q[W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    if (start_i) begin
      r_q <= '0;
    end else if (busy_q) begin
      r_q <= r_d;
    end
  end

  assign done_o = done_q;
  assign p_o    = r_q;

`include "modular_exponentiation_top_assert.svh"

  `MX_ASSERT_ALWAYS(a_no_restart, start_i |-> !busy_q, "multiplier started while busy")
  `MX_ASSERT(a_done_after_busy, done_q |-> $past(busy_q), "done without a running multiply")
  `MX_ASSERT(a_partial_reduced, busy_q |-> (r_q < m_i), "partial product not reduced")

endmodule
